// File: src/wrsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrsi_pkg
// shared types and constants of the wilder rsi stream block
// ----------------------------------------------------------------------------
package wrsi_pkg;

  localparam int PRICE_BITS    = 32;
  localparam int AVG_FRAC_BITS = 32;
  localparam int AVG_BITS      = AVG_FRAC_BITS + 16;
  localparam int AVG_SHIFT     = AVG_FRAC_BITS - 16;
  localparam int ACC_BITS      = 64;
  localparam int DQ_BITS       = 80;
  localparam int RSI_BITS      = 23;
  localparam int STEP_BITS     = 7;
  localparam int PERIOD_BITS   = 8;
  localparam int FLOOR_BITS    = 16;

  localparam logic [STEP_BITS-1:0] AVG_STEPS   = STEP_BITS'(ACC_BITS);
  localparam logic [STEP_BITS-1:0] RATIO_STEPS = STEP_BITS'(DQ_BITS);

  localparam logic [1:0] ST_WARM  = 2'd0;
  localparam logic [1:0] ST_VALID = 2'd1;
  localparam logic [1:0] ST_FLOOR = 2'd2;

  localparam logic REG_PERIOD = 1'b0;
  localparam logic REG_FLOOR  = 1'b1;

  typedef struct packed {
    logic                restart;
    logic [AVG_BITS-1:0] gain;
    logic [AVG_BITS-1:0] loss;
  } cmd_t;

  typedef struct packed {
    logic [PERIOD_BITS-1:0] period;
    logic [FLOOR_BITS-1:0]  floor;
  } cfg_t;

endpackage

// File: src/wilder_rsi_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wilder_rsi_stream
// streaming wilder relative strength index over Q16.16 prices
// ----------------------------------------------------------------------------
// One result beat per price beat. Warm-up prices and restarts bypass the
// divider; a price that completes warm-up or is smoothed uses the one
// restoring divider in the back end: 64 steps each for the gain and loss
// averages and 80 steps for the ratio, which is skipped when the average loss
// is at or below the floor. A two-entry queue lets the next prices be taken
// while a result is computed, and the output register holds a result until
// taken. Register 0 is the smoothing period (0 acts as 1), register 1 the
// Q0.16 loss floor; write them only while the block is idle.
// ----------------------------------------------------------------------------
module wilder_rsi_stream
  import wrsi_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // price[31:0]
  input  logic [0:0]  s_tuser,   // series_start[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // rsi_value[22:0], zero pad[23]
  output logic [1:0]  m_tuser,   // rsi_status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t                cfg;
  cmd_t                push_cmd;
  cmd_t                pop_cmd;
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;
  logic [RSI_BITS-1:0] rsi_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period <= PERIOD_BITS'(14);
      cfg.floor  <= FLOOR_BITS'(1);
    end else if (cfg_valid) begin
      case (cfg_index[0])
        REG_PERIOD: cfg.period <= cfg_data[PERIOD_BITS-1:0];
        REG_FLOOR:  cfg.floor  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  wrsi_front u_front (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .price        (s_tdata),
    .series_start (s_tuser[0]),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  wrsi_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (push_cmd),
    .pop   (q_pop),
    .rdata (pop_cmd),
    .full  (q_full),
    .empty (q_empty)
  );

  wrsi_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .rsi_value  (rsi_value),
    .rsi_status (m_tuser)
  );

  assign m_tdata = {1'b0, rsi_value};

endmodule

// File: src/wrsi_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrsi_fifo
// short register queue between the classifier and the arithmetic back end
// ----------------------------------------------------------------------------
module wrsi_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push && !full) - CW'(pop && !empty);
    end
  end

endmodule

// File: src/wrsi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrsi_front
// accepts prices and splits each change into gain and loss commands
// ----------------------------------------------------------------------------
module wrsi_front
  import wrsi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [PRICE_BITS-1:0] price,
  input  logic                  series_start,
  input  logic                  q_full,
  output logic                  q_push,
  output cmd_t                  q_cmd
);

  logic [PRICE_BITS-1:0] last_price;
  logic                  has_price;
  logic [PRICE_BITS-1:0] diff;
  logic                  up;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;
  assign up       = price > last_price;
  assign diff     = up ? price - last_price : last_price - price;

  // changes of PRICE_BITS always fit the average format, no saturation needed
  always_comb begin
    q_cmd.restart = series_start || !has_price;
    q_cmd.gain    = '0;
    q_cmd.loss    = '0;
    if (!q_cmd.restart) begin
      if (up) begin
        q_cmd.gain = AVG_BITS'(diff) << AVG_SHIFT;
      end else begin
        q_cmd.loss = AVG_BITS'(diff) << AVG_SHIFT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      last_price <= price;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      has_price <= 1'b0;
    end else if (q_push) begin
      has_price <= 1'b1;
    end
  end

endmodule

// File: src/wrsi_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrsi_back
// wilder averaging and rsi ratio on one shared serial divider
// ----------------------------------------------------------------------------
module wrsi_back
  import wrsi_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                q_empty,
  input  cmd_t                q_cmd,
  output logic                q_pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [RSI_BITS-1:0] rsi_value,
  output logic [1:0]          rsi_status
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_DIVG  = 3'd2;
  localparam logic [2:0] S_DIVL  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_RATIO = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]             state;
  logic [PERIOD_BITS-1:0] changes_seen;
  logic [ACC_BITS-1:0]    gain_average;
  logic [ACC_BITS-1:0]    loss_average;
  logic [AVG_BITS-1:0]    gain;
  logic [AVG_BITS-1:0]    loss;
  logic [ACC_BITS-1:0]    dvd_l;
  logic [ACC_BITS-1:0]    rem;
  logic [DQ_BITS-1:0]     dq;
  logic [ACC_BITS-1:0]    dvs;
  logic [STEP_BITS-1:0]   steps;
  logic [RSI_BITS-1:0]    res_value;
  logic [1:0]             res_status;

  logic [PERIOD_BITS-1:0] per;
  logic [PERIOD_BITS-1:0] per_m1;
  logic [PERIOD_BITS-1:0] cnt_inc;
  logic [ACC_BITS-1:0]    sum_g;
  logic [ACC_BITS-1:0]    sum_l;
  logic [ACC_BITS+PERIOD_BITS-1:0] prod_g;
  logic [ACC_BITS+PERIOD_BITS-1:0] prod_l;
  logic [ACC_BITS-1:0]    sm_g;
  logic [ACC_BITS-1:0]    sm_l;
  logic [ACC_BITS+6:0]    g100;
  logic [ACC_BITS-1:0]    floor_avg;
  logic [ACC_BITS-1:0]    rem_sh;
  logic                   ge;
  logic                   emit_ok;

  assign per     = (cfg.period == '0) ? PERIOD_BITS'(1) : cfg.period;
  assign per_m1  = per - 1'b1;
  assign cnt_inc = changes_seen + 1'b1;
  assign sum_g   = gain_average + ACC_BITS'(gain);
  assign sum_l   = loss_average + ACC_BITS'(loss);
  assign prod_g  = gain_average * per_m1;
  assign prod_l  = loss_average * per_m1;
  assign sm_g    = prod_g[ACC_BITS-1:0] + ACC_BITS'(gain);
  assign sm_l    = prod_l[ACC_BITS-1:0] + ACC_BITS'(loss);
  assign g100    = (71'(gain_average) << 6) + (71'(gain_average) << 5)
                 + (71'(gain_average) << 2);
  assign floor_avg = ACC_BITS'(cfg.floor) << AVG_SHIFT;

  // one restoring step
  assign rem_sh  = {rem[ACC_BITS-2:0], dq[DQ_BITS-1]};
  assign ge      = rem_sh >= dvs;
  assign emit_ok = !m_tvalid || m_tready;
  assign q_pop   = (state == S_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (state == S_DIVG || state == S_DIVL || state == S_RATIO) begin
      if (steps != '0) begin
        rem   <= ge ? rem_sh - dvs : rem_sh;
        dq    <= {dq[DQ_BITS-2:0], ge};
        steps <= steps - 1'b1;
      end
    end
    case (state)
      S_IDLE: begin
        gain <= q_cmd.gain;
        loss <= q_cmd.loss;
        res_value  <= '0;
        res_status <= ST_WARM;
      end
      S_PREP: begin
        rem   <= '0;
        dvs   <= ACC_BITS'(per);
        steps <= AVG_STEPS;
        if (changes_seen < per) begin
          dq    <= {sum_g, 16'b0};
          dvd_l <= sum_l;
        end else begin
          dq    <= {sm_g, 16'b0};
          dvd_l <= sm_l;
        end
      end
      S_DIVG: begin
        if (steps == '0) begin
          rem   <= '0;
          dq    <= {dvd_l, 16'b0};
          steps <= AVG_STEPS;
        end
      end
      S_CHECK: begin
        rem   <= '0;
        dq    <= {g100[ACC_BITS-1:0], 16'b0};
        dvs   <= gain_average + loss_average;
        steps <= RATIO_STEPS;
        if (loss_average <= floor_avg) begin
          res_status <= ST_FLOOR;
        end
      end
      S_RATIO: begin
        if (steps == '0) begin
          res_value  <= dq[RSI_BITS-1:0];
          res_status <= ST_VALID;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      changes_seen <= '0;
      gain_average <= '0;
      loss_average <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            if (q_cmd.restart) begin
              changes_seen <= '0;
              gain_average <= '0;
              loss_average <= '0;
              state        <= S_EMIT;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          if (changes_seen < per) begin
            changes_seen <= cnt_inc;
            if (cnt_inc >= per) begin
              state <= S_DIVG;
            end else begin
              gain_average <= sum_g;
              loss_average <= sum_l;
              state        <= S_EMIT;
            end
          end else begin
            changes_seen <= per;
            state        <= S_DIVG;
          end
        end
        S_DIVG: begin
          if (steps == '0) begin
            gain_average <= dq[ACC_BITS-1:0];
            state        <= S_DIVL;
          end
        end
        S_DIVL: begin
          if (steps == '0) begin
            loss_average <= dq[ACC_BITS-1:0];
            state        <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= (loss_average <= floor_avg) ? S_EMIT : S_RATIO;
        end
        S_RATIO: begin
          if (steps == '0) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == S_EMIT && emit_ok) begin
      rsi_value  <= res_value;
      rsi_status <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_EMIT && emit_ok) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  a_zero_unless_valid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && rsi_status != ST_VALID) |-> (rsi_value == '0))
    else $error("rsi value nonzero without valid status");

  a_divg_to_divl: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVG && steps == '0) |=> (state == S_DIVL))
    else $error("gain division not followed by loss division");

  a_restart_emits: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_cmd.restart) |=> (state == S_EMIT && res_status == ST_WARM))
    else $error("restart did not give a warm-up result");

  a_divider_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVG || state == S_DIVL) |-> (steps <= AVG_STEPS))
    else $error("average division step count out of range");

endmodule
